// ===== sv/job_timer_table_top_assert.svh =====
// Assertion macros for the job timer table.
`ifndef JOB_TIMER_TABLE_TOP_ASSERT_SVH
`define JOB_TIMER_TABLE_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define JTT_ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define JTT_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define JTT_ASSERT_IMPL(label, clk, rst, prop, msg)
`define JTT_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

// ===== sv/jtt_pkg.sv =====
// Shared types and constants for the job timer table.
`timescale 1ns / 1ps
package jtt_pkg;
   localparam int SLOTS_DEFAULT = 16;
   localparam logic [31:0] MAX_SPAN = 32'h7fffffff;

   typedef enum logic [2:0] {
      OP_AT_WALL    = 3'd0,
      OP_AFTER      = 3'd1,
      OP_EVERY_WALL = 3'd2,
      OP_EVERY_MONO = 3'd3,
      OP_REMOVE_TAG = 3'd4,
      OP_REMOVE_ID  = 3'd5,
      OP_CLEAR      = 3'd6,
      OP_TICK       = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_BAD_ARG  = 3'd1,
      ST_DUP_TAG  = 3'd2,
      ST_FULL     = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_FIRE,
      S_COMMIT,
      S_REPLY
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic scan_step;
      logic fire_apply;
      logic commit;
      logic send_fire;
      logic send_reply;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_done;
      logic hit_fire;
      logic early_done;
      logic rsp_free;
   } sts_type;
endpackage

// ===== sv/jtt_ctrl.sv =====
// Controller state machine sequencing the slot scan.
`timescale 1ns / 1ps
module jtt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  jtt_pkg::sts_type  sts,
   output jtt_pkg::cmd_type  cmd,
   output jtt_pkg::state_type state
);
   jtt_pkg::state_type state_ff, state_in;

   // hold state
   always_ff @(posedge clock) begin
      if (reset) state_ff <= jtt_pkg::S_IDLE;
      else state_ff <= state_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         jtt_pkg::S_IDLE:
            if (req_valid) state_in = jtt_pkg::S_SCAN;
         jtt_pkg::S_SCAN: begin
            if (sts.hit_fire) state_in = jtt_pkg::S_FIRE;
            else if (sts.scan_done || sts.early_done) state_in = jtt_pkg::S_COMMIT;
         end
         jtt_pkg::S_FIRE:
            if (sts.rsp_free) state_in = sts.scan_done ? jtt_pkg::S_COMMIT : jtt_pkg::S_SCAN;
         // wait until the last fired word has left the result register
         jtt_pkg::S_COMMIT:
            if (sts.rsp_free) state_in = jtt_pkg::S_REPLY;
         jtt_pkg::S_REPLY:
            if (sts.rsp_free) state_in = jtt_pkg::S_IDLE;
         default: state_in = jtt_pkg::S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         jtt_pkg::S_IDLE: begin
            req_ready = 1'b1;
            cmd.load = req_valid;
         end
         jtt_pkg::S_SCAN: cmd.scan_step = !sts.hit_fire;
         jtt_pkg::S_FIRE: begin
            cmd.send_fire = sts.rsp_free;
            cmd.fire_apply = sts.rsp_free;
         end
         jtt_pkg::S_COMMIT: cmd.commit = sts.rsp_free;
         jtt_pkg::S_REPLY: cmd.send_reply = sts.rsp_free;
         default: ;
      endcase
   end

   assign state = state_ff;
endmodule

// ===== sv/jtt_dp.sv =====
// Datapath: slot table, scan index, request word and result register.
`timescale 1ns / 1ps
module jtt_dp #(
   parameter int SLOTS = jtt_pkg::SLOTS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  jtt_pkg::cmd_type cmd,
   output jtt_pkg::sts_type sts,
   input  logic [2:0]       req_op,
   input  logic [15:0]      req_tag,
   input  logic [31:0]      req_amount,
   input  logic [30:0]      req_job_id,
   input  logic [31:0]      req_mono_now,
   input  logic [31:0]      req_wall_now,
   input  logic             req_wall_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_kind,
   output logic [30:0]      rsp_job_id_res,
   output logic [2:0]       rsp_status,
   output logic             rsp_last
);
   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);

   logic [SLOTS-1:0] act_ff;
   logic [SLOTS-1:0] wall_ff;
   logic [30:0] id_ff [SLOTS];
   logic [15:0] tag_ff [SLOTS];
   logic [31:0] due_ff [SLOTS];
   logic [30:0] ivl_ff [SLOTS];
   logic [31:0] next_id_ff;

   jtt_pkg::op_type op_ff;
   logic [15:0] tag_r_ff;
   logic [31:0] amt_ff, mono_ff, wall_now_ff;
   logic [30:0] jid_ff;
   logic wrdy_ff;

   logic [CW-1:0] idx_ff;
   logic [IW-1:0] free_ff;
   logic free_ok_ff, dup_ff, found_ff;
   logic [IW-1:0] found_at_ff;

   logic rv_ff, rkind_ff, rlast_ff;
   logic [30:0] rid_ff;
   logic [2:0] rst_ff;

   logic [IW-1:0] ix;
   logic is_add, is_tick, is_rem, match, due_now, start_wall;
   logic [31:0] wsum, msum, d;
   logic bad_amt;
   logic [2:0] add_st;
   logic [31:0] limit;

   assign ix = idx_ff[IW-1:0];
   assign is_add = (op_ff == jtt_pkg::OP_AT_WALL) || (op_ff == jtt_pkg::OP_AFTER) ||
                   (op_ff == jtt_pkg::OP_EVERY_WALL) || (op_ff == jtt_pkg::OP_EVERY_MONO);
   assign is_tick = (op_ff == jtt_pkg::OP_TICK);
   assign is_rem = (op_ff == jtt_pkg::OP_REMOVE_TAG) || (op_ff == jtt_pkg::OP_REMOVE_ID);
   assign limit = next_id_ff - 32'd1;
   assign wsum = wall_now_ff + {1'b0, ivl_ff[ix]};
   assign msum = mono_ff + {1'b0, ivl_ff[ix]};
   assign d = mono_ff - due_ff[ix];

   // per-slot evaluation at the scan index
   always_comb begin
      match = 1'b0;
      if (act_ff[ix]) begin
         if (op_ff == jtt_pkg::OP_REMOVE_TAG) match = (tag_r_ff != 16'd0) && (tag_ff[ix] == tag_r_ff);
         else match = (id_ff[ix] == jid_ff);
      end
      start_wall = 1'b0;
      due_now = 1'b0;
      if (act_ff[ix] && ({1'b0, id_ff[ix]} <= limit)) begin
         if (wall_ff[ix]) begin
            if (wrdy_ff) begin
               if (due_ff[ix] == 32'd0 && ivl_ff[ix] != 31'd0) start_wall = 1'b1;
               else due_now = (wall_now_ff >= due_ff[ix]);
            end
         end else begin
            due_now = !d[31];
         end
      end
   end

   // add status
   always_comb begin
      case (op_ff)
         jtt_pkg::OP_AT_WALL: bad_amt = (amt_ff == 32'd0);
         jtt_pkg::OP_AFTER:   bad_amt = (amt_ff > jtt_pkg::MAX_SPAN);
         default:             bad_amt = (amt_ff == 32'd0) || (amt_ff > jtt_pkg::MAX_SPAN);
      endcase
      if (bad_amt || tag_r_ff == 16'd0) add_st = jtt_pkg::ST_BAD_ARG;
      else if (next_id_ff == 32'd0 || next_id_ff > jtt_pkg::MAX_SPAN) add_st = jtt_pkg::ST_FULL;
      else if (dup_ff) add_st = jtt_pkg::ST_DUP_TAG;
      else if (!free_ok_ff) add_st = jtt_pkg::ST_FULL;
      else add_st = jtt_pkg::ST_OK;
   end

   assign sts.scan_done = (idx_ff >= CW'(SLOTS - 1)) && !(is_tick && idx_ff < CW'(SLOTS));
   assign sts.hit_fire = is_tick && (idx_ff < CW'(SLOTS)) && due_now;
   assign sts.early_done = !is_tick && (idx_ff >= CW'(SLOTS) || (is_rem && match)
                           || op_ff == jtt_pkg::OP_CLEAR);
   assign sts.rsp_free = !rv_ff || rsp_ready;

   // capture request and run the scan
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= jtt_pkg::op_type'(req_op);
         tag_r_ff <= req_tag;
         amt_ff <= req_amount;
         jid_ff <= req_job_id;
         mono_ff <= req_mono_now;
         wall_now_ff <= req_wall_now;
         wrdy_ff <= req_wall_ready;
         idx_ff <= '0;
         free_ok_ff <= 1'b0;
         free_ff <= '0;
         dup_ff <= 1'b0;
         found_ff <= 1'b0;
         found_at_ff <= '0;
      end else if (cmd.scan_step || cmd.fire_apply) begin
         if (idx_ff < CW'(SLOTS)) idx_ff <= idx_ff + CW'(1);
         if (cmd.scan_step && idx_ff < CW'(SLOTS)) begin
            if (!act_ff[ix] && !free_ok_ff) begin
               free_ok_ff <= 1'b1;
               free_ff <= ix;
            end
            if (act_ff[ix] && tag_ff[ix] == tag_r_ff) dup_ff <= 1'b1;
         end
      end
      if (cmd.scan_step && !is_tick && is_rem && match && idx_ff < CW'(SLOTS)) begin
         found_ff <= 1'b1;
         found_at_ff <= ix;
      end
   end

   // slot table writes
   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= '0;
         next_id_ff <= 32'd1;
      end else begin
         if (cmd.scan_step && is_tick && start_wall && idx_ff < CW'(SLOTS))
            due_ff[ix] <= wsum;
         if (cmd.fire_apply) begin
            if (ivl_ff[ix] == 31'd0) begin
               act_ff[ix] <= 1'b0;
               wall_ff[ix] <= 1'b0;
               id_ff[ix] <= '0; tag_ff[ix] <= '0; due_ff[ix] <= '0; ivl_ff[ix] <= '0;
            end else due_ff[ix] <= wall_ff[ix] ? wsum : msum;
         end
         if (cmd.commit) begin
            if (op_ff == jtt_pkg::OP_CLEAR) act_ff <= '0;
            else if (is_rem && found_ff) act_ff[found_at_ff] <= 1'b0;
            else if (is_add && add_st == jtt_pkg::ST_OK) begin
               act_ff[free_ff] <= 1'b1;
               id_ff[free_ff] <= next_id_ff[30:0];
               tag_ff[free_ff] <= tag_r_ff;
               wall_ff[free_ff] <= (op_ff == jtt_pkg::OP_AT_WALL) ||
                                   (op_ff == jtt_pkg::OP_EVERY_WALL);
               ivl_ff[free_ff] <= (op_ff == jtt_pkg::OP_EVERY_WALL ||
                                   op_ff == jtt_pkg::OP_EVERY_MONO) ? amt_ff[30:0] : 31'd0;
               case (op_ff)
                  jtt_pkg::OP_AT_WALL: due_ff[free_ff] <= amt_ff;
                  jtt_pkg::OP_EVERY_WALL:
                     due_ff[free_ff] <= wrdy_ff ? wall_now_ff + amt_ff : 32'd0;
                  default: due_ff[free_ff] <= mono_ff + amt_ff;
               endcase
               next_id_ff <= next_id_ff + 32'd1;
            end
         end
      end
   end

   // result register; reply word decided at commit
   always_ff @(posedge clock) begin
      if (reset) rv_ff <= 1'b0;
      else if (cmd.send_fire) begin
         rv_ff <= 1'b1;
         rkind_ff <= 1'b1; rid_ff <= id_ff[ix]; rst_ff <= jtt_pkg::ST_OK; rlast_ff <= 1'b0;
      end else if (cmd.send_reply) begin
         rv_ff <= 1'b1;
         rkind_ff <= 1'b0; rlast_ff <= 1'b1;
      end else if (rsp_ready) rv_ff <= 1'b0;
      if (cmd.commit) begin
         if (is_add) begin
            rst_ff <= add_st;
            rid_ff <= (add_st == jtt_pkg::ST_OK) ? next_id_ff[30:0] : 31'd0;
         end else begin
            rst_ff <= (is_rem && !found_ff) ? jtt_pkg::ST_NOTFOUND : jtt_pkg::ST_OK;
            rid_ff <= '0;
         end
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_kind = rkind_ff;
   assign rsp_job_id_res = rid_ff;
   assign rsp_status = rst_ff;
   assign rsp_last = rlast_ff;
endmodule

// ===== sv/job_timer_table_top.sv =====
// Top level of the job timer table.
`timescale 1ns / 1ps
// Usage: one request word (op plus operands and time stamps) enters on the
// req_ valid/ready channel while the block is idle. The block scans its slots
// one per cycle, pausing at each due job, and answers on the rsp_ channel: a
// tick yields one fired word per due job (kind 1, last 0) and then a reply
// word (kind 0, last 1); every other op yields a single reply word with its
// status and, for adds, new id. An add or a tick scans every slot; remove
// stops at the matching slot and clear skips the scan. One request is in
// flight at a time: a new request is taken only once the reply of the last
// has been issued and the block is idle again. Reset (synchronous, active
// high) empties every slot and sets the next id to one. When the receiver
// holds rsp_ready low, the result register holds its word, the scan pauses
// at the firing slot and the reply waits until the word is taken.
module job_timer_table_top #(
   parameter int SLOTS = jtt_pkg::SLOTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_op,
   input  logic [15:0] req_tag,
   input  logic [31:0] req_amount,
   input  logic [30:0] req_job_id,
   input  logic [31:0] req_mono_now,
   input  logic [31:0] req_wall_now,
   input  logic        req_wall_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [30:0] rsp_job_id_res,
   output logic [2:0]  rsp_status,
   output logic        rsp_last
);
`include "job_timer_table_top_assert.svh"

   jtt_pkg::cmd_type cmd;
   jtt_pkg::sts_type sts;
   jtt_pkg::state_type state;

   jtt_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .sts(sts), .cmd(cmd), .state(state)
   );

   jtt_dp #(.SLOTS(SLOTS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .req_op(req_op), .req_tag(req_tag), .req_amount(req_amount),
      .req_job_id(req_job_id), .req_mono_now(req_mono_now),
      .req_wall_now(req_wall_now), .req_wall_ready(req_wall_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_kind(rsp_kind),
      .rsp_job_id_res(rsp_job_id_res), .rsp_status(rsp_status), .rsp_last(rsp_last)
   );

   `JTT_ASSERT_NEVER(a_ready_idle, clock, reset, req_ready && state != jtt_pkg::S_IDLE, "ready outside idle")
   `JTT_ASSERT_NEVER(a_fire_kind, clock, reset, rsp_valid && rsp_kind && (rsp_last || rsp_status != jtt_pkg::ST_OK), "fired word malformed")
   `JTT_ASSERT_IMPL(a_reply_idle, clock, reset, (state == jtt_pkg::S_REPLY && sts.rsp_free) |=> req_ready, "reply not followed by idle")
endmodule
